FILE: hdl/sdm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and microcode rom for the signed division magic generator
package sdm_pkg;

  localparam logic [31:0] Two31   = 32'h8000_0000;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [5:0]  PInit   = 6'd31;
  localparam logic [5:0]  PLast   = 6'd63;
  localparam logic [4:0]  DivLast = 5'd31;

  typedef logic [3:0] upc_t;

  localparam upc_t UpcWait  = 4'd0;
  localparam upc_t UpcDiv1  = 4'd1;
  localparam upc_t UpcAnc   = 4'd2;
  localparam upc_t UpcDiv2  = 4'd3;
  localparam upc_t UpcPrep  = 4'd4;
  localparam upc_t UpcDiv3  = 4'd5;
  localparam upc_t UpcStep1 = 4'd6;
  localparam upc_t UpcStep2 = 4'd7;
  localparam upc_t UpcTest  = 4'd8;
  localparam upc_t UpcFin   = 4'd9;

  typedef enum logic [6:0] {
    OP_WAIT = 7'b0000001,
    OP_DIV  = 7'b0000010,
    OP_ANC  = 7'b0000100,
    OP_PREP = 7'b0001000,
    OP_DBL  = 7'b0010000,
    OP_TEST = 7'b0100000,
    OP_FIN  = 7'b1000000
  } op_t;

  typedef struct packed {
    op_t  op;
    logic pair2;
    logic den_anc;
    upc_t jmp;
  } ctrl_t;

  function automatic ctrl_t sdm_urom(input upc_t addr);
    ctrl_t cw;
    case (addr)
      UpcWait:  cw = '{OP_WAIT, 1'b0, 1'b0, UpcFin};
      UpcDiv1:  cw = '{OP_DIV,  1'b0, 1'b0, UpcWait};
      UpcAnc:   cw = '{OP_ANC,  1'b0, 1'b0, UpcWait};
      UpcDiv2:  cw = '{OP_DIV,  1'b0, 1'b1, UpcWait};
      UpcPrep:  cw = '{OP_PREP, 1'b1, 1'b0, UpcWait};
      UpcDiv3:  cw = '{OP_DIV,  1'b1, 1'b0, UpcWait};
      UpcStep1: cw = '{OP_DBL,  1'b0, 1'b1, UpcWait};
      UpcStep2: cw = '{OP_DBL,  1'b1, 1'b0, UpcWait};
      UpcTest:  cw = '{OP_TEST, 1'b0, 1'b1, UpcStep2};
      UpcFin:   cw = '{OP_FIN,  1'b0, 1'b0, UpcWait};
      default:  cw = '{OP_FIN,  1'b0, 1'b0, UpcWait};
    endcase
    return cw;
  endfunction

endpackage

FILE: hdl/sdm_cmpsub.sv
`timescale 1ns / 1ps
// shared compare-subtract unit for restoring division and doubling steps
module sdm_cmpsub
  import sdm_pkg::*;
(
  input  logic [32:0] num_i,
  input  logic [31:0] den_i,
  output logic        ge_o,
  output logic [31:0] diff_o
);

  logic [32:0] diff_full;

  assign diff_full = num_i - {1'b0, den_i};
  assign ge_o      = (num_i >= {1'b0, den_i});
  assign diff_o    = diff_full[31:0];

endmodule

FILE: hdl/signed_div_magic_number.sv
`timescale 1ns / 1ps
// top level: microcoded magic multiplier and shift generator for signed division
// divisor 0, 1, -1 and int_min skip straight from accept to the result
// otherwise the result follows the divisions and k = 1..32 doubling iterations;
// three 32-step restoring divisions and the doubling loop share one compare-subtract unit
// one item at a time; the next item is accepted once the result sits in the output register
// synchronous active-low reset clears the microcode counter and the output valid flag
module signed_div_magic_number
  import sdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_divisor_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_magic_valid,
  output logic signed [31:0] out_magic_multiplier,
  output logic [4:0]         out_post_shift
);

  ctrl_t       cw;
  upc_t        upc_r, upc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [5:0]  p_r, p_nxt;
  logic        neg_r, neg_nxt;
  logic        spec_r, spec_nxt;
  logic [31:0] ad_r, ad_nxt;
  logic [31:0] anc_r, anc_nxt;
  logic [32:0] q1_r, q1_nxt;
  logic [31:0] r1_r, r1_nxt;
  logic [31:0] q2_r, q2_nxt;
  logic [31:0] r2_r, r2_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_mv_r, out_mv_nxt;
  logic [31:0] out_mult_r, out_mult_nxt;
  logic [4:0]  out_shift_r, out_shift_nxt;

  logic        in_acc;
  logic        out_free;
  logic [31:0] d_u;
  logic        spec_in;
  logic [31:0] ad_in;
  logic [31:0] rem_sel;
  logic [31:0] den_sel;
  logic        sh_in;
  logic        ge;
  logic [31:0] diff;
  logic [31:0] rem_new;
  logic        step_en;
  logic [31:0] delta;
  logic        keep_going;
  logic        loop_exit;
  logic [31:0] m_pos;
  logic [31:0] m_out;

  assign cw       = sdm_urom(upc_r);
  assign in_stall = (cw.op != OP_WAIT);
  assign in_acc   = in_valid && (cw.op == OP_WAIT);
  assign out_free = !out_valid_r || !out_stall;

  assign d_u     = in_divisor_in;
  assign spec_in = (d_u == 32'd0) || (d_u == 32'd1) || (d_u == AllOnes) || (d_u == Two31);
  assign ad_in   = d_u[31] ? (~d_u + 32'd1) : d_u;

  // shared compare-subtract operands
  assign rem_sel = cw.pair2 ? r2_r : r1_r;
  assign den_sel = cw.den_anc ? anc_r : ad_r;
  assign sh_in   = (cw.op == OP_DIV) && (cw.pair2 ? q2_r[31] : q1_r[31]);

  sdm_cmpsub u_cmpsub (
    .num_i  ({rem_sel, sh_in}),
    .den_i  (den_sel),
    .ge_o   (ge),
    .diff_o (diff)
  );

  assign rem_new = ge ? diff : {rem_sel[30:0], sh_in};

  // exit test on registered quotients and remainders
  assign delta      = ad_r - r2_r;
  assign keep_going = (q1_r < {1'b0, delta}) || ((q1_r == {1'b0, delta}) && (r1_r == 32'd0));
  assign loop_exit  = !keep_going || (p_r == PLast);

  assign m_pos = q2_r + 32'd1;
  assign m_out = neg_r ? (~m_pos + 32'd1) : m_pos;

  always_comb begin
    upc_nxt       = upc_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    neg_nxt       = neg_r;
    spec_nxt      = spec_r;
    ad_nxt        = ad_r;
    anc_nxt       = anc_r;
    q1_nxt        = q1_r;
    r1_nxt        = r1_r;
    q2_nxt        = q2_r;
    r2_nxt        = r2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mv_nxt    = out_mv_r;
    out_mult_nxt  = out_mult_r;
    out_shift_nxt = out_shift_r;
    step_en       = 1'b0;

    case (cw.op)
      OP_WAIT: begin
        if (in_acc) begin
          neg_nxt  = d_u[31];
          ad_nxt   = ad_in;
          spec_nxt = spec_in;
          q1_nxt   = {1'b0, Two31 | {31'd0, d_u[31]}};
          r1_nxt   = 32'd0;
          cnt_nxt  = DivLast;
          upc_nxt  = spec_in ? cw.jmp : upc_r + 4'd1;
        end
      end
      OP_DIV: begin
        step_en = 1'b1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          upc_nxt = upc_r + 4'd1;
        end
      end
      OP_ANC: begin
        anc_nxt = (Two31 | {31'd0, neg_r}) - 32'd1 - r1_r;
        q1_nxt  = {1'b0, Two31};
        r1_nxt  = 32'd0;
        cnt_nxt = DivLast;
        upc_nxt = upc_r + 4'd1;
      end
      OP_PREP: begin
        q2_nxt  = Two31;
        r2_nxt  = 32'd0;
        cnt_nxt = DivLast;
        p_nxt   = PInit;
        upc_nxt = upc_r + 4'd1;
      end
      OP_DBL: begin
        step_en = 1'b1;
        if (!cw.pair2) begin
          p_nxt = p_r + 6'd1;
        end
        upc_nxt = upc_r + 4'd1;
      end
      OP_TEST: begin
        if (loop_exit) begin
          upc_nxt = upc_r + 4'd1;
        end else begin
          step_en = 1'b1;
          p_nxt   = p_r + 6'd1;
          upc_nxt = cw.jmp;
        end
      end
      OP_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mv_nxt    = !spec_r;
          out_mult_nxt  = spec_r ? 32'd0 : m_out;
          out_shift_nxt = spec_r ? 5'd0 : p_r[4:0];
          upc_nxt       = cw.jmp;
        end
      end
      default: begin
        upc_nxt = UpcWait;
      end
    endcase

    // shift quotient left, take the compare result as new bit
    if (step_en) begin
      if (cw.pair2) begin
        q2_nxt = {q2_r[30:0], ge};
        r2_nxt = rem_new;
      end else begin
        q1_nxt = {q1_r[31:0], ge};
        r1_nxt = rem_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UpcWait;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    p_r         <= p_nxt;
    neg_r       <= neg_nxt;
    spec_r      <= spec_nxt;
    ad_r        <= ad_nxt;
    anc_r       <= anc_nxt;
    q1_r        <= q1_nxt;
    r1_r        <= r1_nxt;
    q2_r        <= q2_nxt;
    r2_r        <= r2_nxt;
    out_mv_r    <= out_mv_nxt;
    out_mult_r  <= out_mult_nxt;
    out_shift_r <= out_shift_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_magic_valid      = out_mv_r;
  assign out_magic_multiplier = out_mult_r;
  assign out_post_shift       = out_shift_r;

  a_spec_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && spec_in) |=> (cw.op == OP_FIN))
    else $error("unsupported divisor did not go straight to finish");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ((cw.op == OP_DIV) || (cw.op == OP_DBL)) |-> (rem_sel < den_sel))
    else $error("remainder not below divisor");

  a_test_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_TEST) |-> (p_r > PInit))
    else $error("exit test reached without a doubling step");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cw.op == OP_FIN))
    else $error("result item raised outside finish step");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_mv_r) |-> ((out_mult_r == 32'd0) && (out_shift_r == 5'd0)))
    else $error("unsupported divisor result not zero");

endmodule
